[hw/rtl/bmf_pkg.sv]
// shared types, constants and register codes of the box mean filter
package bmf_pkg;

  localparam int PIXEL_BITS       = 16;
  localparam int DEF_MAX_WIDTH    = 1024;
  localparam int DEF_MAX_WINDOW   = 15;

  localparam int WIDTH_REG_W      = 11;
  localparam int HEIGHT_REG_W     = 16;
  localparam int WINDOW_REG_W     = 4;
  localparam int CFG_DATA_W       = 16;
  localparam int CFG_INDEX_W      = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_SIZE  = 2'd2;

  localparam logic [WIDTH_REG_W-1:0]  RST_IMAGE_WIDTH  = 11'd640;
  localparam logic [HEIGHT_REG_W-1:0] RST_IMAGE_HEIGHT = 16'd480;
  localparam logic [WINDOW_REG_W-1:0] RST_WINDOW_SIZE  = 4'd3;

  typedef struct packed {
    logic signed [PIXEL_BITS-1:0] pixel_in;
    logic                         drain;
  } in_item_t;

  typedef struct packed {
    logic signed [PIXEL_BITS-1:0] pixel_out;
    logic                         interior;
    logic                         frame_last;
  } out_item_t;

endpackage

[hw/rtl/bmf_line_mem.sv]
// line store: synchronous ram, one write port and one registered read port
module bmf_line_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 16
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hw/rtl/bmf_divider.sv]
// iterative restoring divider, one quotient bit per cycle
module bmf_divider #(
  parameter int DW = 24,
  parameter int NW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [NW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic [NW-1:0] rem;
  logic [NW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [NW:0]   trial;
  logic          fits;

  assign trial = {rem, quotient[DW-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CW'(DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      if (fits) begin
        rem <= NW'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[NW-1:0];
      end
      quotient <= {quotient[DW-2:0], fits};
    end
  end

endmodule

[hw/rtl/box_mean_filter_2d.sv]
// box mean filter top level: counters, window sequencer and output register
//
// Pixels enter on the in channel (valid/stall) in raster order; results leave on
// the out channel in the same raster order, delayed by d*W + d pixels where
// d = S-1-S/2. Once a frame is complete, further requests (drain or pixel) push
// out the remaining results; the result flagged frame_last restarts counting.
// Each request is handled to completion before the next is taken; its states:
//   no result       : S_MUL, S_CMP, then back to S_IDLE
//   border pixel    : S_MUL, S_CMP, S_PASS, S_OUT
//   interior pixel  : S_MUL, S_CMP, S_SUM over the S*S window, S_LAST,
//                     S_DSTART, S_DIV to divide when the sum is positive, S_OUT
// The window sum reads the line store one pixel per cycle through its single
// read port; a positive sum's mean comes from a bit-serial divider, else 0.
// The result sits in an output register; a stalled receiver holds it and the
// block waits there before loading the next one. Reset clears counters and
// control; the line store is not cleared. The user writes registers through
// cfg_write/cfg_index/cfg_data between frames; the block does not enforce it.
module box_mean_filter_2d #(
  parameter int MAX_WIDTH  = bmf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_WINDOW = bmf_pkg::DEF_MAX_WINDOW
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  bmf_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output bmf_pkg::out_item_t               out_data,
  input  logic                             cfg_write,
  input  logic [bmf_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [bmf_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import bmf_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int RW    = $clog2(MAX_WINDOW);
  localparam int SW    = $clog2(MAX_WINDOW + 1);
  localparam int NW    = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
  localparam int SUM_W = PIXEL_BITS + NW;
  localparam int POS_W = HEIGHT_REG_W + WW + 2;
  localparam int AW    = RW + CW;
  localparam int DEPTH = MAX_WINDOW << CW;
  localparam int HW    = HEIGHT_REG_W;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_MUL    = 9'b000000010,
    S_CMP    = 9'b000000100,
    S_SUM    = 9'b000001000,
    S_LAST   = 9'b000010000,
    S_DSTART = 9'b000100000,
    S_DIV    = 9'b001000000,
    S_PASS   = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_t;

  state_t state;

  logic [WIDTH_REG_W-1:0]  image_width;
  logic [HEIGHT_REG_W-1:0] image_height;
  logic [WINDOW_REG_W-1:0] window_size;

  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [SW-1:0] s_eff;
  logic [SW-1:0] rad;
  logic [SW-1:0] dl;
  logic [NW-1:0] n_area;

  logic [HW-1:0] in_row, out_row;
  logic [CW-1:0] in_col, out_col;
  logic [RW-1:0] in_ring, out_ring;

  logic [POS_W-1:0] prod_in, prod_out, lag;
  logic [RW-1:0]    win_ring;
  logic [CW-1:0]    col0, col_ptr;
  logic [SW-1:0]    k_cnt, l_cnt;
  logic             rd_valid;
  logic signed [SUM_W-1:0] sum;
  logic signed [PIXEL_BITS-1:0] res;
  logic             inner_q;

  logic             accept;
  logic             store;
  logic [WW-1:0]    in_col_inc;
  logic             full;
  logic [POS_W-1:0] received, limit;
  logic             inner;
  logic [RW:0]      top_ring;
  logic             mem_rd_en;
  logic [AW-1:0]    mem_rd_addr;
  logic [PIXEL_BITS-1:0] mem_rd_data;
  logic             div_start, div_done;
  logic [SUM_W-1:0] quotient;
  logic             out_free;
  logic [WW-1:0]    out_col_inc;
  logic [HW:0]      out_row_inc;
  logic             out_wrap;
  logic             last;

  function automatic logic [RW-1:0] ring_inc(input logic [RW-1:0] x);
    ring_inc = (x == RW'(MAX_WINDOW - 1)) ? '0 : x + 1'b1;
  endfunction

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RST_IMAGE_WIDTH;
      image_height <= RST_IMAGE_HEIGHT;
      window_size  <= RST_WINDOW_SIZE;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[HEIGHT_REG_W-1:0];
        REG_WINDOW_SIZE:  window_size  <= cfg_data[WINDOW_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_width == '0) begin
      w_eff = WW'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(image_width);
    end
    h_eff = (image_height == '0) ? HW'(1) : image_height;
    if (window_size == '0) begin
      s_eff = SW'(1);
    end else if (32'(window_size) > MAX_WINDOW) begin
      s_eff = SW'(MAX_WINDOW);
    end else begin
      s_eff = SW'(window_size);
    end
    rad    = s_eff >> 1;
    dl     = s_eff - 1'b1 - rad;
    n_area = NW'(s_eff * s_eff);
  end

  assign in_stall   = (state != S_IDLE);
  assign accept     = in_valid && !in_stall;
  assign store      = accept && !in_data.drain && (in_row < h_eff);
  assign in_col_inc = WW'(in_col) + 1'b1;

  assign full     = in_row >= h_eff;
  assign received = prod_in + POS_W'(in_col);
  assign limit    = prod_out + POS_W'(out_col) + lag;
  assign inner    = (out_row >= HW'(rad))
                 && ((HW + 1)'(out_row) + (HW + 1)'(rad) < (HW + 1)'(h_eff))
                 && (WW'(out_col) >= WW'(rad))
                 && ((WW + 1)'(out_col) + (WW + 1)'(rad) < (WW + 1)'(w_eff));
  assign top_ring = (out_ring >= RW'(rad)) ? (RW + 1)'(out_ring) - (RW + 1)'(rad)
                  : (RW + 1)'(out_ring) + (RW + 1)'(MAX_WINDOW) - (RW + 1)'(rad);

  assign mem_rd_en   = (state == S_CMP) || (state == S_SUM);
  assign mem_rd_addr = (state == S_CMP) ? {out_ring, out_col} : {win_ring, col_ptr};

  assign div_start = (state == S_DSTART) && (sum > 0);

  assign out_free    = !out_valid || !out_stall;
  assign out_col_inc = WW'(out_col) + 1'b1;
  assign out_wrap    = out_col_inc >= w_eff;
  assign out_row_inc = (HW + 1)'(out_row) + 1'b1;
  assign last        = out_wrap && (out_row_inc >= (HW + 1)'(h_eff));

  bmf_line_mem #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (PIXEL_BITS)
  ) u_line_mem (
    .clk     (clk),
    .wr_en   (store),
    .wr_addr ({in_ring, in_col}),
    .wr_data (in_data.pixel_in),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  bmf_divider #(
    .DW (SUM_W),
    .NW (NW)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum),
    .divisor  (n_area),
    .done     (div_done),
    .quotient (quotient)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_row    <= '0;
      in_col    <= '0;
      in_ring   <= '0;
      out_row   <= '0;
      out_col   <= '0;
      out_ring  <= '0;
      out_valid <= 1'b0;
      rd_valid  <= 1'b0;
    end else begin
      rd_valid <= (state == S_SUM);
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (store) begin
            if (in_col_inc >= w_eff) begin
              in_col  <= '0;
              in_row  <= in_row + 1'b1;
              in_ring <= ring_inc(in_ring);
            end else begin
              in_col <= CW'(in_col_inc);
            end
          end
          if (accept) begin
            state <= S_MUL;
          end
        end
        S_MUL: state <= S_CMP;
        S_CMP: begin
          if (!full && received <= limit) begin
            state <= S_IDLE;
          end else if (inner) begin
            state <= S_SUM;
          end else begin
            state <= S_PASS;
          end
        end
        S_SUM: begin
          if (l_cnt == s_eff - 1'b1 && k_cnt == s_eff - 1'b1) begin
            state <= S_LAST;
          end
        end
        S_LAST:   state <= S_DSTART;
        S_DSTART: state <= (sum > 0) ? S_DIV : S_OUT;
        S_DIV: begin
          if (div_done) begin
            state <= S_OUT;
          end
        end
        S_PASS: state <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
            if (last) begin
              in_row   <= '0;
              in_col   <= '0;
              in_ring  <= '0;
              out_row  <= '0;
              out_col  <= '0;
              out_ring <= '0;
            end else if (out_wrap) begin
              out_col  <= '0;
              out_row  <= out_row + 1'b1;
              out_ring <= ring_inc(out_ring);
            end else begin
              out_col <= CW'(out_col_inc);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_MUL: begin
        prod_in  <= POS_W'(in_row * w_eff);
        prod_out <= POS_W'(out_row * w_eff);
        lag      <= POS_W'(dl * w_eff) + POS_W'(dl);
      end
      S_CMP: begin
        inner_q  <= inner;
        win_ring <= top_ring[RW-1:0];
        col0     <= CW'(WW'(out_col) - WW'(rad));
        col_ptr  <= CW'(WW'(out_col) - WW'(rad));
        k_cnt    <= '0;
        l_cnt    <= '0;
        sum      <= '0;
      end
      S_SUM: begin
        if (l_cnt == s_eff - 1'b1) begin
          l_cnt    <= '0;
          col_ptr  <= col0;
          win_ring <= ring_inc(win_ring);
          k_cnt    <= k_cnt + 1'b1;
        end else begin
          l_cnt   <= l_cnt + 1'b1;
          col_ptr <= col_ptr + 1'b1;
        end
        if (rd_valid) begin
          sum <= sum + SUM_W'(signed'(mem_rd_data));
        end
      end
      S_LAST: begin
        if (rd_valid) begin
          sum <= sum + SUM_W'(signed'(mem_rd_data));
        end
      end
      S_DSTART: begin
        if (sum <= 0) begin
          res <= '0;
        end
      end
      S_DIV: begin
        if (div_done) begin
          res <= quotient[PIXEL_BITS-1:0];
        end
      end
      S_PASS: res <= mem_rd_data;
      S_OUT: begin
        if (out_free) begin
          out_data.pixel_out  <= res;
          out_data.interior   <= inner_q;
          out_data.frame_last <= last;
        end
      end
      default: ;
    endcase
  end

endmodule
